@@ src/skc_pkg.sv @@
package skc_pkg;

    localparam int MAX_ENTRIES   = 128;
    localparam int MAX_ENTRY_LEN = 32;
    localparam int IDX_W         = $clog2(MAX_ENTRIES);
    localparam int POS_W         = $clog2(MAX_ENTRY_LEN);
    localparam int LEN_W         = POS_W + 1;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TEXT = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_APOS  = 8'h27;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic             load_en;
        logic [IDX_W-1:0] load_entry;
        logic [POS_W-1:0] load_pos;
        logic [7:0]       load_char;
        logic             load_final;
        logic             scan_en;
        logic [7:0]       scan_char;
        logic             delim;
        logic             after_delim;
        logic             dot;
        logic             clear;
        logic             shift;
    } skc_bcast_t;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

endpackage

@@ src/skc_cell.sv @@
module skc_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [skc_pkg::IDX_W-1:0] cell_idx,
    input  skc_pkg::skc_bcast_t      bc,
    input  logic                     tally_in,
    output logic                     tally_out
);
    import skc_pkg::*;

    logic [7:0]             chars_reg [MAX_ENTRY_LEN];
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [MAX_ENTRY_LEN-1:0] pm_reg, pm_next;
    logic                   pend_reg, pend_next;
    logic                   found_reg, found_next;
    logic                   tally_reg, tally_next;
    logic [MAX_ENTRY_LEN-1:0] eq;
    logic [MAX_ENTRY_LEN-1:0] bits;
    logic                   full;
    logic                   load_here;

    assign load_here = bc.load_en && (bc.load_entry == cell_idx);

    // character compare per position, limited to the entry length
    always_comb begin
        for (int k = 0; k < MAX_ENTRY_LEN; k++) begin
            eq[k] = (chars_reg[k] == bc.scan_char) && (LEN_W'(k) < len_reg);
        end
        bits = ((pm_reg << 1) | MAX_ENTRY_LEN'(bc.after_delim)) & eq;
        full = (len_reg != '0) && bits[POS_W'(len_reg - LEN_W'(1))];
    end

    // next state of the matching cell
    always_comb begin
        len_next   = len_reg;
        pm_next    = pm_reg;
        pend_next  = pend_reg;
        found_next = found_reg;
        tally_next = tally_reg;
        if (load_here && bc.load_final) begin
            len_next = LEN_W'(bc.load_pos) + LEN_W'(1);
        end
        if (bc.scan_en) begin
            found_next = found_reg | (pend_reg & bc.delim);
            pend_next  = 1'b0;
            pm_next    = bits;
            if (full) begin
                if (bc.dot) found_next = 1'b1;
                else        pend_next  = 1'b1;
            end
            if (bc.dot) begin
                tally_next = found_next;
                pm_next    = '0;
                pend_next  = 1'b0;
                found_next = 1'b0;
            end
        end
        if (bc.clear) begin
            pm_next    = '0;
            pend_next  = 1'b0;
            found_next = 1'b0;
        end
        if (bc.shift) begin
            tally_next = tally_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            pm_reg    <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            tally_reg <= 1'b0;
        end else begin
            len_reg   <= len_next;
            pm_reg    <= pm_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            tally_reg <= tally_next;
        end
    end

    // dictionary characters, stored case-folded
    always_ff @(posedge aclk) begin
        if (load_here) begin
            chars_reg[bc.load_pos] <= fold_lower(bc.load_char);
        end
    end

    assign tally_out = tally_reg;

endmodule

@@ src/sentence_keyword_counter.sv @@
// A result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while the output is not stalled; a text byte
// '.' is followed by a count pass in which the per-entry found flags shift
// down the cell chain into the total, and no item is accepted during it.
// Reset (aresetn low, synchronous): entry lengths, match state, total and
// words_in_use clear; dictionary characters stay undefined until loaded.
module sentence_keyword_counter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,    // words_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,        // entry_index[6:0], char_position[11:7], char_value[19:12]
    input  logic        s_tlast,        // entry_final
    input  logic [1:0]  s_tuser,        // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,        // echo_char[7:0], sentence_word_total[39:8]
    output logic        m_tuser         // is_total
);
    import skc_pkg::*;

    logic [1:0]       action;
    logic [7:0]       ch_low;
    logic             accept;
    logic             is_text;
    skc_bcast_t       bc;
    logic [MAX_ENTRIES:0] chain;

    logic [7:0]       words_reg;
    logic             after_reg, after_next;
    logic [31:0]      total_reg, total_next;
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             mvalid_reg, mvalid_next;
    logic [7:0]       echo_reg, echo_next;
    logic [31:0]      mtotal_reg, mtotal_next;
    logic             istot_reg, istot_next;
    logic [8:0]       limit;

    assign action   = s_tuser;
    assign ch_low   = fold_lower(s_tdata[19:12]);
    assign s_tready = !busy_reg && (!mvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign is_text  = accept && (action == ACT_TEXT);
    assign limit    = (words_reg > 8'(MAX_ENTRIES)) ? 9'(MAX_ENTRIES) : {1'b0, words_reg};

    // broadcast to the cells
    always_comb begin
        bc.load_en     = accept && (action == ACT_LOAD);
        bc.load_entry  = s_tdata[6:0];
        bc.load_pos    = s_tdata[11:7];
        bc.load_char   = s_tdata[19:12];
        bc.load_final  = s_tlast;
        bc.scan_en     = is_text;
        bc.scan_char   = ch_low;
        bc.delim       = (ch_low == CH_SPACE) || (ch_low == CH_DOT) ||
                         (ch_low == CH_COMMA) || (ch_low == CH_APOS);
        bc.after_delim = after_reg;
        bc.dot         = ch_low == CH_DOT;
        bc.clear       = accept && (action == ACT_END);
        bc.shift       = busy_reg;
    end

    // chain of matching cells; tallies shift toward cell 0
    assign chain[MAX_ENTRIES] = 1'b0;
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        skc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (IDX_W'(i)),
            .bc        (bc),
            .tally_in  (chain[i+1]),
            .tally_out (chain[i])
        );
    end

    // sequencing, count pass and output register
    always_comb begin
        after_next  = after_reg;
        total_next  = total_reg;
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        echo_next   = echo_reg;
        mtotal_next = mtotal_reg;
        istot_next  = istot_reg;
        if (busy_reg) begin
            if (chain[0] && ({2'b0, cnt_reg} < limit) && (total_reg != '1)) begin
                total_next = total_reg + 32'd1;
            end
            cnt_next = cnt_reg + IDX_W'(1);
            if (cnt_reg == IDX_W'(MAX_ENTRIES - 1)) busy_next = 1'b0;
        end
        if (is_text) begin
            after_next  = bc.delim;
            mvalid_next = 1'b1;
            echo_next   = fold_upper(s_tdata[19:12]);
            mtotal_next = '0;
            istot_next  = 1'b0;
            if (bc.dot) begin
                busy_next = 1'b1;
                cnt_next  = '0;
            end
        end
        if (bc.clear) begin
            after_next  = 1'b1;
            mvalid_next = 1'b1;
            echo_next   = '0;
            mtotal_next = total_reg;
            istot_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg  <= '0;
            after_reg  <= 1'b1;
            total_reg  <= '0;
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) words_reg <= cfg_wr_data;
            after_reg  <= after_next;
            total_reg  <= total_next;
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
        echo_reg   <= echo_next;
        mtotal_reg <= mtotal_next;
        istot_reg  <= istot_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {mtotal_reg, echo_reg};
    assign m_tuser  = istot_reg;

endmodule
